### sv/ptd_pkg.sv
package ptd_pkg;

   // command codes carried on req_command
   typedef enum logic {
      CMD_CREATE   = 1'b0,
      CMD_OVERFLOW = 1'b1
   } command_type;

   typedef enum logic [1:0] {
      SCHED_IDLE,
      SCHED_WALK,
      SCHED_FLUSH,
      SCHED_FINISH
   } sched_state_type;

   // one slot entry as held in the slot memory
   typedef struct packed {
      logic [7:0] period;
      logic [7:0] countdown;
   } entry_type;

   // decoded request from the top level to the scheduler
   typedef struct packed {
      logic       create;
      logic       tick;
      logic [2:0] slot;
      logic       running;
      logic [7:0] period;
      logic [7:0] delay;
   } sched_cmd_type;

   localparam logic [15:0] TICK_COUNT_RESET = 16'd32;

endpackage

### sv/ptd_slot_ram.sv
module ptd_slot_ram #(
   parameter int DEPTH = 8,
   parameter int AW    = 3
) (
   input  logic                clock,
   input  logic                we,
   input  logic [AW-1:0]       waddr,
   input  ptd_pkg::entry_type  wdata,
   input  logic [AW-1:0]       raddr,
   output ptd_pkg::entry_type  rdata
);

   ptd_pkg::entry_type mem [DEPTH];
   ptd_pkg::entry_type rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### sv/ptd_sched.sv
module ptd_sched #(
   parameter int SLOTS = 8,
   parameter int AW    = 3
) (
   input  logic                    clock,
   input  logic                    reset,
   input  ptd_pkg::sched_cmd_type  cmd,
   output logic                    busy,
   output logic                    ram_we,
   output logic [AW-1:0]           ram_waddr,
   output ptd_pkg::entry_type      ram_wdata,
   output logic [AW-1:0]           ram_raddr,
   input  ptd_pkg::entry_type      ram_rdata,
   output logic                    rsp_valid,
   output logic [2:0]              rsp_slot,
   output logic                    rsp_last
);

   localparam logic [AW-1:0] LAST_IDX = AW'(SLOTS - 1);

   ptd_pkg::sched_state_type state_ff, state_in;

   logic [SLOTS-1:0] used_ff, used_in;
   logic [SLOTS-1:0] running_ff, running_in;
   logic [AW-1:0]    rd_idx_ff, rd_idx_in;
   logic             b_valid_ff, b_valid_in;
   logic [AW-1:0]    b_idx_ff, b_idx_in;
   logic             pend_valid_ff, pend_valid_in;
   logic [AW-1:0]    pend_idx_ff, pend_idx_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [2:0]       rsp_slot_ff, rsp_slot_in;
   logic             rsp_last_ff, rsp_last_in;
   logic [AW-1:0]    create_idx;

   assign create_idx = AW'(cmd.slot);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ptd_pkg::SCHED_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff       <= '0;
         running_ff    <= '0;
         b_valid_ff    <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         used_ff       <= used_in;
         running_ff    <= running_in;
         b_valid_ff    <= b_valid_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      rd_idx_ff   <= rd_idx_in;
      b_idx_ff    <= b_idx_in;
      pend_idx_ff <= pend_idx_in;
      rsp_slot_ff <= rsp_slot_in;
      rsp_last_ff <= rsp_last_in;
   end

   // The walk reads slot k while it writes back slot k-1, so the read and
   // the write never touch the same entry; creates only land while idle.
   always_comb begin
      state_in      = state_ff;
      used_in       = used_ff;
      running_in    = running_ff;
      rd_idx_in     = rd_idx_ff;
      b_valid_in    = 1'b0;
      b_idx_in      = rd_idx_ff;
      pend_valid_in = pend_valid_ff;
      pend_idx_in   = pend_idx_ff;
      rsp_valid_in  = 1'b0;
      rsp_slot_in   = 3'(pend_idx_ff);
      rsp_last_in   = 1'b0;
      ram_we        = 1'b0;
      ram_waddr     = b_idx_ff;
      ram_wdata     = ram_rdata;
      ram_raddr     = rd_idx_ff;

      unique case (state_ff)
         ptd_pkg::SCHED_IDLE: begin
            if (cmd.create) begin
               used_in[create_idx]    = 1'b1;
               running_in[create_idx] = cmd.running;
               ram_we                 = 1'b1;
               ram_waddr              = create_idx;
               ram_wdata.period       = (cmd.period == 8'd0) ? 8'd1 : cmd.period;
               ram_wdata.countdown    = cmd.delay;
            end
            if (cmd.tick) begin
               state_in  = ptd_pkg::SCHED_WALK;
               rd_idx_in = '0;
            end
         end
         ptd_pkg::SCHED_WALK: begin
            b_valid_in = 1'b1;
            if (rd_idx_ff == LAST_IDX) begin
               state_in = ptd_pkg::SCHED_FLUSH;
            end else begin
               rd_idx_in = rd_idx_ff + 1'b1;
            end
         end
         ptd_pkg::SCHED_FLUSH: begin
            state_in = ptd_pkg::SCHED_FINISH;
         end
         ptd_pkg::SCHED_FINISH: begin
            // the held dispatch is the final one of this tick
            if (pend_valid_ff) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = 1'b1;
            end
            pend_valid_in = 1'b0;
            state_in      = ptd_pkg::SCHED_IDLE;
         end
         default: begin
            state_in = ptd_pkg::SCHED_IDLE;
         end
      endcase

      if (b_valid_ff && used_ff[b_idx_ff] && running_ff[b_idx_ff]) begin
         ram_we = 1'b1;
         if (ram_rdata.countdown == 8'd0) begin
            ram_wdata.countdown = ram_rdata.period - 8'd1;
            // release the previously held dispatch, hold this one
            if (pend_valid_ff) begin
               rsp_valid_in = 1'b1;
            end
            pend_valid_in = 1'b1;
            pend_idx_in   = b_idx_ff;
         end else begin
            ram_wdata.countdown = ram_rdata.countdown - 8'd1;
         end
      end
   end

   assign busy      = (state_ff != ptd_pkg::SCHED_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_slot  = rsp_slot_ff;
   assign rsp_last  = rsp_last_ff;

   a_tick_only_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.tick |-> state_ff == ptd_pkg::SCHED_IDLE)
      else $error("tick issued while a walk is in progress");

   a_no_pend_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == ptd_pkg::SCHED_IDLE |-> !pend_valid_ff)
      else $error("dispatch still held while idle");

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_last_ff |=> !rsp_valid_ff)
      else $error("result after the final dispatch of a tick");

   a_walk_starts: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(cmd.tick))
      else $error("walk started without a tick");

endmodule

### sv/periodic_task_dispatcher.sv
// Channel   | Ports                                         | Transfer
// ----------+-----------------------------------------------+---------------------------
// request   | start, busy, req_command .. req_task_running | start && !busy
// response  | rsp_valid, rsp_dispatched_slot, rsp_last      | rsp_valid, one cycle
// csr       | csr_we, csr_wdata                             | csr_we
//
// A create or a non-ticking overflow leaves busy low.
// A ticking overflow walks the slot memory one slot per cycle, as set by the
// single memory read port, and holds busy through the walk, flush and finish states.
// Each result is held until the walk finds the next due slot or ends, so the
// final one appears in the first cycle with busy low.
// Reset clears the slot flags and the overflow count; the slot memory needs no
// clearing. The response side cannot stall.
module periodic_task_dispatcher #(
   parameter int SLOTS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_command,
   input  logic [2:0]  req_task_slot,
   input  logic [7:0]  req_period,
   input  logic [7:0]  req_initial_delay,
   input  logic        req_task_running,
   output logic        rsp_valid,
   output logic [2:0]  rsp_dispatched_slot,
   output logic        rsp_last,
   input  logic        csr_we,
   input  logic [15:0] csr_wdata
);

   localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   logic [15:0] tick_count_ff, tick_count_in;
   logic [15:0] overflow_count_ff, overflow_count_in;
   logic [15:0] count_next;
   logic        accept;
   logic        reached;
   logic        slot_ok;

   ptd_pkg::sched_cmd_type cmd;
   ptd_pkg::entry_type     ram_wdata;
   ptd_pkg::entry_type     ram_rdata;
   logic                   ram_we;
   logic [AW-1:0]          ram_waddr;
   logic [AW-1:0]          ram_raddr;

   assign accept     = start && !busy;
   assign count_next = overflow_count_ff + 16'd1;
   assign reached    = (count_next >= tick_count_ff);
   assign slot_ok    = (32'(req_task_slot) < SLOTS);

   always_comb begin
      tick_count_in     = tick_count_ff;
      overflow_count_in = overflow_count_ff;
      if (csr_we) begin
         tick_count_in = csr_wdata;
      end
      if (accept && req_command == ptd_pkg::CMD_OVERFLOW) begin
         overflow_count_in = reached ? 16'd0 : count_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_count_ff     <= ptd_pkg::TICK_COUNT_RESET;
         overflow_count_ff <= '0;
      end else begin
         tick_count_ff     <= tick_count_in;
         overflow_count_ff <= overflow_count_in;
      end
   end

   always_comb begin
      cmd.create  = accept && (req_command == ptd_pkg::CMD_CREATE) && slot_ok;
      cmd.tick    = accept && (req_command == ptd_pkg::CMD_OVERFLOW) && reached;
      cmd.slot    = req_task_slot;
      cmd.running = req_task_running;
      cmd.period  = req_period;
      cmd.delay   = req_initial_delay;
   end

   ptd_slot_ram #(
      .DEPTH (SLOTS),
      .AW    (AW)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   ptd_sched #(
      .SLOTS (SLOTS),
      .AW    (AW)
   ) u_sched (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .busy      (busy),
      .ram_we    (ram_we),
      .ram_waddr (ram_waddr),
      .ram_wdata (ram_wdata),
      .ram_raddr (ram_raddr),
      .ram_rdata (ram_rdata),
      .rsp_valid (rsp_valid),
      .rsp_slot  (rsp_dispatched_slot),
      .rsp_last  (rsp_last)
   );

endmodule

### sim/tb_periodic_task_dispatcher.sv
module tb_periodic_task_dispatcher;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int SLOT_COUNT = 8;
   localparam int CSR_SETTLE = 16;
   localparam int DRAIN_CYCLES = 20;

   typedef struct packed {
      logic [2:0] slot;
      logic       last;
   } dispatch_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic        req_command = ptd_pkg::CMD_CREATE;
   logic [2:0]  req_task_slot = '0;
   logic [7:0]  req_period = '0;
   logic [7:0]  req_initial_delay = '0;
   logic        req_task_running = 1'b0;
   logic        rsp_valid;
   logic [2:0]  rsp_dispatched_slot;
   logic        rsp_last;
   logic        csr_we = 1'b0;
   logic [15:0] csr_wdata = '0;

   periodic_task_dispatcher #(.SLOTS(SLOT_COUNT)) uut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_command         (req_command),
      .req_task_slot       (req_task_slot),
      .req_period          (req_period),
      .req_initial_delay   (req_initial_delay),
      .req_task_running    (req_task_running),
      .rsp_valid           (rsp_valid),
      .rsp_dispatched_slot (rsp_dispatched_slot),
      .rsp_last            (rsp_last),
      .csr_we              (csr_we),
      .csr_wdata           (csr_wdata)
   );

   always #5 clock = ~clock;

   // scheduler shadow state
   logic        slot_used [SLOT_COUNT];
   logic        slot_running [SLOT_COUNT];
   logic [7:0]  slot_countdown [SLOT_COUNT];
   logic [7:0]  slot_period [SLOT_COUNT];
   logic [15:0] overflow_count;
   logic [15:0] overflows_per_tick;

   dispatch_type pending_dispatches[$];

   int mismatches = 0;
   int requests_sent = 0;
   int creates_sent = 0;
   int ticks_fired = 0;
   int dispatches_seen = 0;
   int prescale_writes = 0;

   int idle_max = 0;
   int pending_gap = 0;
   bit start_held = 1'b0;

   function automatic void advance_scheduler(ptd_pkg::command_type cmd, logic [2:0] slot,
         logic [7:0] per, logic [7:0] dly, logic run);
      logic [2:0] due [SLOT_COUNT];
      int n;
      dispatch_type d;
      n = 0;
      if (cmd == ptd_pkg::CMD_CREATE) begin
         slot_used[slot] = 1'b1;
         slot_running[slot] = run;
         slot_period[slot] = (per == 8'd0) ? 8'd1 : per;
         slot_countdown[slot] = dly;
         creates_sent++;
         return;
      end
      overflow_count = overflow_count + 16'd1;
      if (overflow_count < overflows_per_tick)
         return;
      overflow_count = '0;
      ticks_fired++;
      for (int k = 0; k < SLOT_COUNT; k++) begin
         if (slot_used[k] && slot_running[k]) begin
            if (slot_countdown[k] == 8'd0) begin
               due[n] = k[2:0];
               n++;
               slot_countdown[k] = slot_period[k] - 8'd1;
            end else begin
               slot_countdown[k] = slot_countdown[k] - 8'd1;
            end
         end
      end
      for (int i = 0; i < n; i++) begin
         d.slot = due[i];
         d.last = (i == n - 1);
         pending_dispatches.push_back(d);
      end
   endfunction

   always @(posedge clock) begin : check_dispatch
      dispatch_type want;
      if (!reset && rsp_valid === 1'b1) begin
         dispatches_seen++;
         if (pending_dispatches.size() == 0) begin
            $error("unexpected dispatch: dispatched_slot %0d last %0b",
                   rsp_dispatched_slot, rsp_last);
            mismatches++;
         end else begin
            want = pending_dispatches.pop_front();
            if (rsp_dispatched_slot !== want.slot) begin
               $error("dispatched_slot: expected %0d, got %0d", want.slot,
                      rsp_dispatched_slot);
               mismatches++;
            end
            if (rsp_last !== want.last) begin
               $error("last: expected %0b, got %0b", want.last, rsp_last);
               mismatches++;
            end
         end
      end
   end

   task automatic send_request(ptd_pkg::command_type cmd, logic [2:0] slot,
         logic [7:0] per, logic [7:0] dly, logic run);
      repeat (pending_gap) @(posedge clock);
      req_command <= cmd;
      req_task_slot <= slot;
      req_period <= per;
      req_initial_delay <= dly;
      req_task_running <= run;
      start <= 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
      advance_scheduler(cmd, slot, per, dly, run);
      requests_sent++;
      pending_gap = (idle_max == 0) ? 0 : $urandom_range(0, idle_max);
      // keep start high only when the next transfer follows back to back
      if (pending_gap != 0)
         start <= 1'b0;
      start_held = (pending_gap == 0);
   endtask

   task automatic park_requester();
      if (start_held) begin
         start <= 1'b0;
         start_held = 1'b0;
         if (pending_gap == 0)
            pending_gap = 1;
      end
   endtask

   task automatic wait_for_dispatches();
      park_requester();
      while (pending_dispatches.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_prescale(logic [15:0] value);
      wait_for_dispatches();
      // a tick with nothing due may still be walking the slots
      repeat (CSR_SETTLE) @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      overflows_per_tick = value;
      prescale_writes++;
   endtask

   task automatic create_slot(logic [2:0] slot, logic [7:0] per, logic [7:0] dly,
         logic run);
      send_request(ptd_pkg::CMD_CREATE, slot, per, dly, run);
   endtask

   task automatic pulse_overflow(int count);
      repeat (count)
         send_request(ptd_pkg::CMD_OVERFLOW, 3'($urandom_range(0, 7)),
                      8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)));
   endtask

   task automatic test_default_prescale();
      idle_max = 0;
      create_slot(3'd0, 8'd1, 8'd0, 1'b1);
      pulse_overflow(31);
      // hold until the count is one short of the tick: nothing may dispatch
      wait_for_dispatches();
      pulse_overflow(1);
   endtask

   task automatic test_period_extremes();
      write_prescale(16'd1);
      idle_max = 11;
      create_slot(3'd7, 8'd255, 8'd255, 1'b1);
      create_slot(3'd0, 8'd0, 8'd0, 1'b1);
      create_slot(3'd3, 8'd2, 8'd0, 1'b0);
      create_slot(3'd5, 8'd1, 8'd1, 1'b1);
      pulse_overflow(3);
      create_slot(3'd7, 8'd2, 8'd0, 1'b1);
      pulse_overflow(2);
   endtask

   task automatic test_nothing_due();
      write_prescale(16'd0);
      create_slot(3'd0, 8'd5, 8'd9, 1'b1);
      create_slot(3'd5, 8'd4, 8'd3, 1'b0);
      create_slot(3'd7, 8'd1, 8'd200, 1'b1);
      pulse_overflow(2);
   endtask

   task automatic test_all_slots_due();
      idle_max = 0;
      for (int k = 0; k < SLOT_COUNT; k++)
         create_slot(k[2:0], 8'd0, 8'd0, 1'b1);
      pulse_overflow(2);
   endtask

   task automatic test_prescale_lowered();
      write_prescale(16'hFFFF);
      idle_max = 11;
      pulse_overflow(3);
      // count is now above the new setting: the next overflow ticks
      write_prescale(16'd2);
      pulse_overflow(1);
   endtask

   task automatic test_random_traffic();
      logic [15:0] phase_prescale [6] = '{16'd1, 16'd2, 16'd0, 16'd3, 16'd5, 16'd4};
      int          phase_idle [6] = '{11, 0, 11, 11, 0, 11};
      logic [2:0]  slot;
      logic [7:0]  per;
      logic [7:0]  dly;
      for (int p = 0; p < 6; p++) begin
         write_prescale(phase_prescale[p]);
         idle_max = phase_idle[p];
         for (int i = 0; i < 70; i++) begin
            if ($urandom_range(0, 3) == 0) begin
               slot = 3'($urandom_range(0, 7));
               if ($urandom_range(0, 7) == 0)
                  per = 8'($urandom_range(0, 255));
               else
                  per = 8'($urandom_range(0, 6));
               if ($urandom_range(0, 7) == 0)
                  dly = 8'($urandom_range(0, 255));
               else
                  dly = 8'($urandom_range(0, 6));
               create_slot(slot, per, dly, $urandom_range(0, 6) != 0);
            end else begin
               pulse_overflow(1);
            end
            if ($urandom_range(0, 39) == 0)
               wait_for_dispatches();
         end
      end
   endtask

   initial begin
      for (int k = 0; k < SLOT_COUNT; k++) begin
         slot_used[k] = 1'b0;
         slot_running[k] = 1'b0;
         slot_countdown[k] = '0;
         slot_period[k] = '0;
      end
      overflow_count = '0;
      overflows_per_tick = ptd_pkg::TICK_COUNT_RESET;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_default_prescale();
      test_period_extremes();
      test_nothing_due();
      test_all_slots_due();
      test_prescale_lowered();
      test_random_traffic();

      wait_for_dispatches();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_dispatches.size() != 0) begin
         $error("%0d expected dispatches never arrived", pending_dispatches.size());
         mismatches++;
      end
      $display("Run covered %0d requests (%0d creates), %0d scheduler ticks, %0d dispatches",
               requests_sent, creates_sent, ticks_fired, dispatches_seen);
      $display("Prescale written %0d times, settings 0, 1 and 65535 included",
               prescale_writes);
      if (mismatches == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

   initial begin
      #3ms;
      $display("Timed out waiting for the dispatcher");
      $display("FAILURE");
      $finish;
   end

endmodule
